FILE: src/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf-8 validating decoder
// holds the queue entry type passed from the front part to the back part
// no dependencies
package utf8d_pkg;

  // code points and utf-16 surrogate constants
  localparam logic [20:0] Replacement = 21'h00FFFD;
  localparam logic [20:0] MaxCode     = 21'h10FFFF;
  localparam logic [20:0] SurrHigh    = 21'h00D800;
  localparam logic [20:0] SurrLow     = 21'h00DC00;
  localparam logic [20:0] SurrLast    = 21'h00DFFF;
  localparam logic [20:0] PlaneBase   = 21'h010000;
  localparam logic [20:0] BmpLast     = 21'h00FFFF;

  // smallest legal value per sequence length
  localparam logic [20:0] Min2 = 21'h000080;
  localparam logic [20:0] Min3 = 21'h000800;
  localparam logic [20:0] Min4 = 21'h010000;

  // lead byte ranges
  localparam logic [7:0] Lead2First = 8'hC2;
  localparam logic [7:0] Lead2Last  = 8'hDF;
  localparam logic [7:0] Lead3First = 8'hE0;
  localparam logic [7:0] Lead3Last  = 8'hEF;
  localparam logic [7:0] Lead4First = 8'hF0;
  localparam logic [7:0] Lead4Last  = 8'hF4;
  localparam logic [7:0] AsciiLimit = 8'h80;

  // sequence lengths
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // default depth of the queue between the two parts
  localparam int unsigned QueueDepth = 4;

  // one queue entry: the results caused by one input item
  typedef struct packed {
    logic [2:0]  rep_cnt;   // number of replacement results, sent first
    logic        has_code;  // a decoded code point follows the replacements
    logic [20:0] code;      // the decoded code point
    logic        fin;       // the item closed the text
  } desc_t;

endpackage

FILE: src/utf8_validating_decoder.sv
// utf8_validating_decoder: top level of the utf-8 to utf-32/utf-16 decoder
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// Takes one utf-8 byte per cycle on the s_axis side (tlast marks the last
// byte of a text) and gives code points, or utf-16 units when utf16_output
// is set, on the m_axis side. Invalid bytes and broken, truncated, overlong,
// surrogate or out-of-range sequences give U+FFFD with tuser[0] set, one for
// the lead byte and one per continuation byte taken in; a byte that breaks a
// sequence is then decoded afresh. A byte yields zero to four items; m_axis
// tlast marks the last item caused by a byte and tuser[1] the last item of a
// text. A byte is taken every cycle while the result queue (QUEUE_DEPTH
// entries, one per byte that yields items) has room; while m_axis_tready is
// high one item goes out per cycle, and many-item bytes hold the input back
// only once the queue fills. Write utf16_output only while no work is pending.
module utf8_validating_decoder #(
  parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // utf16_output
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // is_final
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [20:0] code_unit, [23:21] zero
  output logic [1:0]  m_axis_tuser,    // [0] replaced, [1] text_end
  output logic        m_axis_tlast     // run_end
);
  import utf8d_pkg::*;

  logic        utf16_output_q;
  logic        q_full;
  logic        push;
  desc_t       push_desc;
  logic        head_valid;
  desc_t       head;
  logic        pop;
  logic [20:0] code_unit;
  logic        replaced;
  logic        text_end;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf16_output_q <= 1'b1;
    end else if (cfg_we_i) begin
      utf16_output_q <= cfg_wdata_i;
    end
  end

  utf8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .data_byte_i (s_axis_tdata),
    .is_final_i  (s_axis_tlast),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  utf8d_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  utf8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .utf16_output_i (utf16_output_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .code_unit_o    (code_unit),
    .replaced_o     (replaced),
    .run_end_o      (m_axis_tlast),
    .text_end_o     (text_end)
  );

  assign m_axis_tdata = {3'd0, code_unit};
  assign m_axis_tuser = {text_end, replaced};

endmodule

FILE: src/utf8d_front.sv
// utf8d_front: accepts utf-8 bytes, tracks the open sequence and classifies
// each byte into a queue entry of replacements and an optional code point
// depends on utf8d_pkg
module utf8d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic                is_final_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output utf8d_pkg::desc_t    desc_o
);
  import utf8d_pkg::*;

  logic [20:0] partial_value_q, partial_value_d;
  logic [1:0]  bytes_expected_q, bytes_expected_d;
  logic [2:0]  sequence_length_q, sequence_length_d;
  logic [1:0]  bytes_held_q, bytes_held_d;

  logic  accept;
  desc_t desc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // next state and result entry for the current byte
  always_comb begin
    logic        is_cont;
    logic        do_fresh;
    logic [20:0] v;
    logic [2:0]  held;
    logic [1:0]  left;
    logic [20:0] minimum;
    logic        bad;
    logic [2:0]  len;
    logic [20:0] bits;

    partial_value_d   = partial_value_q;
    bytes_expected_d  = bytes_expected_q;
    sequence_length_d = sequence_length_q;
    bytes_held_d      = bytes_held_q;
    desc.rep_cnt  = 3'd0;
    desc.has_code = 1'b0;
    desc.code     = {13'd0, data_byte_i};
    desc.fin      = is_final_i;

    is_cont  = (data_byte_i[7:6] == 2'b10);
    do_fresh = 1'b0;
    v        = {partial_value_q[14:0], data_byte_i[5:0]};
    held     = {1'b0, bytes_held_q} + 3'd1;
    left     = bytes_expected_q - 2'd1;
    len      = SeqNone;
    bits     = 21'd0;

    unique case (sequence_length_q)
      SeqLen2: minimum = Min2;
      SeqLen3: minimum = Min3;
      default: minimum = Min4;
    endcase
    bad = (v < minimum) || (v > MaxCode) || ((v >= SurrHigh) && (v <= SurrLast));

    if (bytes_expected_q != 2'd0) begin
      if (is_cont) begin
        if (left == 2'd0) begin
          // sequence complete: check the value
          partial_value_d   = 21'd0;
          bytes_expected_d  = 2'd0;
          sequence_length_d = SeqNone;
          bytes_held_d      = 2'd0;
          if (bad) begin
            desc.rep_cnt = held + 3'd1;
          end else begin
            desc.has_code = 1'b1;
            desc.code     = v;
          end
        end else if (is_final_i) begin
          // truncated at end of text
          desc.rep_cnt      = held + 3'd1;
          partial_value_d   = 21'd0;
          bytes_expected_d  = 2'd0;
          sequence_length_d = SeqNone;
          bytes_held_d      = 2'd0;
        end else begin
          partial_value_d  = v;
          bytes_expected_d = left;
          bytes_held_d     = held[1:0];
        end
      end else begin
        // broken sequence: flush, then decode this byte afresh
        desc.rep_cnt      = {1'b0, bytes_held_q} + 3'd1;
        partial_value_d   = 21'd0;
        bytes_expected_d  = 2'd0;
        sequence_length_d = SeqNone;
        bytes_held_d      = 2'd0;
        do_fresh          = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end

    // fresh decode of a byte outside any sequence
    if (do_fresh) begin
      if (data_byte_i < AsciiLimit) begin
        desc.has_code = 1'b1;
        desc.code     = {13'd0, data_byte_i};
      end else begin
        if (data_byte_i >= Lead2First && data_byte_i <= Lead2Last) begin
          len  = SeqLen2;
          bits = {16'd0, data_byte_i[4:0]};
        end else if (data_byte_i >= Lead3First && data_byte_i <= Lead3Last) begin
          len  = SeqLen3;
          bits = {17'd0, data_byte_i[3:0]};
        end else if (data_byte_i >= Lead4First && data_byte_i <= Lead4Last) begin
          len  = SeqLen4;
          bits = {18'd0, data_byte_i[2:0]};
        end
        if (len == SeqNone || is_final_i) begin
          desc.rep_cnt = desc.rep_cnt + 3'd1;
        end else begin
          partial_value_d   = bits;
          sequence_length_d = len;
          bytes_expected_d  = len[1:0] - 2'd1;
          bytes_held_d      = 2'd0;
        end
      end
    end
  end

  assign desc_o = desc;
  assign push_o = accept && ((desc.rep_cnt != 3'd0) || desc.has_code);

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_value_q   <= 21'd0;
      bytes_expected_q  <= 2'd0;
      sequence_length_q <= SeqNone;
      bytes_held_q      <= 2'd0;
    end else if (accept) begin
      partial_value_q   <= partial_value_d;
      bytes_expected_q  <= bytes_expected_d;
      sequence_length_q <= sequence_length_d;
      bytes_held_q      <= bytes_held_d;
    end
  end

endmodule

FILE: src/utf8d_queue.sv
// utf8d_queue: small register queue of result entries between front and back
// depends on utf8d_pkg
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8d_pkg::desc_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output utf8d_pkg::desc_t head_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/utf8d_back.sv
// utf8d_back: expands the head queue entry into result items, one per cycle
// while out_ready_i is high, in utf-16 mode splitting code points above the
// basic plane into surrogate pairs; depends on utf8d_pkg
module utf8d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             utf16_output_i,
  input  logic             head_valid_i,
  input  utf8d_pkg::desc_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [20:0]      code_unit_o,
  output logic             replaced_o,
  output logic             run_end_o,
  output logic             text_end_o
);
  import utf8d_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        split;
  logic [2:0]  total;
  logic [2:0]  code_pos;
  logic [20:0] offset;
  logic        last;
  logic        take;

  assign split  = utf16_output_i && (head_i.code > BmpLast);
  assign offset = head_i.code - PlaneBase;

  // result count for the head entry
  always_comb begin
    total = head_i.rep_cnt;
    if (head_i.has_code) begin
      total = head_i.rep_cnt + (split ? 3'd2 : 3'd1);
    end
  end

  assign code_pos = {1'b0, idx_q} - head_i.rep_cnt;
  assign last     = ({1'b0, idx_q} == (total - 3'd1));

  // result selection
  always_comb begin
    code_unit_o = head_i.code;
    replaced_o  = 1'b0;
    if ({1'b0, idx_q} < head_i.rep_cnt) begin
      code_unit_o = Replacement;
      replaced_o  = 1'b1;
    end else if (split) begin
      if (code_pos == 3'd0) begin
        code_unit_o = SurrHigh + {11'd0, offset[19:10]};
      end else begin
        code_unit_o = SurrLow + {11'd0, offset[9:0]};
      end
    end
  end

  assign out_valid_o = head_valid_i;
  assign run_end_o   = last;
  assign text_end_o  = last && head_i.fin;
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && last;

  // position within the entry
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: bench/tb_utf8_validating_decoder.sv
// tb_utf8_validating_decoder: self-checking bench for the utf-8 decoder
// drives bytes on s_axis, predicts code points or utf-16 units, checks m_axis
// depends on utf8d_pkg and utf8_validating_decoder
module tb_utf8_validating_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  // output mode values of the one register
  localparam logic ModeCodePoint = 1'b0;
  localparam logic ModeUtf16     = 1'b1;

  localparam int ClkHalf     = 6;
  localparam int CycleLimit  = 200_000;
  localparam int SettleCycles = 12;
  localparam int HoldCycles  = 120;
  localparam int PhaseBytes  = 64;
  localparam int NumDirected = 25;

  // one decoded result as seen on m_axis
  typedef struct packed {
    logic [20:0] code;
    logic        rep;
    logic        run_end;
    logic        text_end;
  } unit_t;

  // one input byte, with a hand-typed result where it is obvious
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [20:0] code;
    logic        rep;
  } byte_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // decoder state mirrored by the bench
  logic        utf16_mode = ModeUtf16;
  logic [20:0] seq_bits   = '0;
  logic [1:0]  conts_left = '0;
  logic [2:0]  seq_len    = SeqNone;
  logic [1:0]  conts_held = '0;

  unit_t     byte_units[$];
  unit_t     units_due[$];
  byte_row_t sent_rows[$];
  byte_row_t plan_rows[$];

  int   fails    = 0;
  int   cycles   = 0;
  int   hold_cnt = 0;
  logic hold_req = 1'b0;
  logic quiet_tx = 1'b0;
  logic quiet_rx = 1'b0;

  // directed bytes: extremes, strays, every sequence length and each error kind
  byte_row_t directed_rows [NumDirected] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
    '{8'h80, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hC0, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hF5, 1'b0, 1'b1, Replacement, 1'b1},
    '{8'hFF, 1'b0, 1'b1, Replacement, 1'b1},
    // smallest two-byte code point
    '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // overlong three-byte form
    '{8'hE0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // encoded surrogate
    '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // largest code point, a surrogate pair in utf-16 mode
    '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    // just above the largest code point
    '{8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // sequence broken by a lead byte that itself ends the text
    '{8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hC2, 1'b1, 1'b0, 21'h0, 1'b0}
  };

  utf8_validating_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  always #(ClkHalf) clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("utf8_validating_decoder test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_unit(input logic [20:0] cu, input logic rep);
    unit_t u;
    u = '{code: cu, rep: rep, run_end: 1'b0, text_end: 1'b0};
    byte_units.insert(byte_units.size(), u);
  endfunction

  // whole code point, or a surrogate pair above the bmp in utf-16 mode
  function automatic void add_code_point(input logic [20:0] cp);
    logic [20:0] off;
    if (utf16_mode == ModeUtf16 && cp > BmpLast) begin
      off = cp - PlaneBase;
      add_unit(SurrHigh + {11'd0, off[19:10]}, 1'b0);
      add_unit(SurrLow + {11'd0, off[9:0]}, 1'b0);
    end else begin
      add_unit(cp, 1'b0);
    end
  endfunction

  function automatic void close_sequence();
    seq_bits   = '0;
    conts_left = '0;
    seq_len    = SeqNone;
    conts_held = '0;
  endfunction

  // one replacement for the lead plus one per continuation taken in
  function automatic void replace_sequence(input logic [1:0] held);
    add_unit(Replacement, 1'b1);
    for (int k = 0; k < int'(held); k++) add_unit(Replacement, 1'b1);
    close_sequence();
  endfunction

  // byte seen with no sequence open
  function automatic void start_byte(input logic [7:0] b, input logic fin);
    logic [2:0]  len;
    logic [20:0] bits;
    len  = SeqNone;
    bits = '0;
    if (b < AsciiLimit) begin
      add_unit({13'd0, b}, 1'b0);
      return;
    end
    if (b >= Lead2First && b <= Lead2Last) begin
      len  = SeqLen2;
      bits = {16'd0, b[4:0]};
    end else if (b >= Lead3First && b <= Lead3Last) begin
      len  = SeqLen3;
      bits = {17'd0, b[3:0]};
    end else if (b >= Lead4First && b <= Lead4Last) begin
      len  = SeqLen4;
      bits = {18'd0, b[2:0]};
    end
    if (len == SeqNone) begin
      add_unit(Replacement, 1'b1);
      return;
    end
    // lead byte that ends the text is flushed at once
    if (fin) begin
      add_unit(Replacement, 1'b1);
      close_sequence();
      return;
    end
    seq_bits   = bits;
    seq_len    = len;
    conts_left = 2'(len - 3'd1);
    conts_held = '0;
  endfunction

  // results caused by one byte, left in byte_units
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic [20:0] v;
    logic [1:0]  held;
    logic [20:0] lowest;
    unit_t       last;
    byte_units.delete();
    if (conts_left != 0) begin
      if (b[7:6] == 2'b10) begin
        v    = {seq_bits[14:0], b[5:0]};
        held = conts_held + 2'd1;
        if (conts_left == 2'd1) begin
          lowest = (seq_len == SeqLen2) ? Min2 : (seq_len == SeqLen3) ? Min3 : Min4;
          if (v < lowest || v > MaxCode || (v >= SurrHigh && v <= SurrLast)) begin
            replace_sequence(held);
          end else begin
            close_sequence();
            add_code_point(v);
          end
        end else if (fin) begin
          replace_sequence(held);
        end else begin
          seq_bits   = v;
          conts_left = conts_left - 2'd1;
          conts_held = held;
        end
      end else begin
        // broken sequence, then the byte is taken as new
        replace_sequence(conts_held);
        start_byte(b, fin);
      end
    end else begin
      start_byte(b, fin);
    end
    if (byte_units.size() != 0) begin
      last          = byte_units[byte_units.size() - 1];
      last.run_end  = 1'b1;
      last.text_end = fin;
      byte_units[byte_units.size() - 1] = last;
    end
  endfunction

  // ------------------------------------------------------------ bus monitors

  function automatic void accept_byte();
    byte_row_t r;
    unit_t     u;
    r = '0;
    if (sent_rows.size() != 0) r = sent_rows.pop_front();
    decode_byte(s_axis_tdata, s_axis_tlast);
    if (r.typed) begin
      byte_units.delete();
      u = '{code: r.code, rep: r.rep, run_end: 1'b1, text_end: r.fin};
      byte_units.insert(byte_units.size(), u);
    end
    foreach (byte_units[i]) units_due.insert(units_due.size(), byte_units[i]);
  endfunction

  function automatic void check_unit();
    unit_t want;
    unit_t got;
    got = '{code: m_axis_tdata[20:0], rep: m_axis_tuser[0],
            run_end: m_axis_tlast, text_end: m_axis_tuser[1]};
    if (units_due.size() == 0) begin
      $display("%0t: unexpected item code=%h rep=%b run_end=%b text_end=%b",
               $realtime, got.code, got.rep, got.run_end, got.text_end);
      fails++;
      return;
    end
    want = units_due.pop_front();
    if (got.code != want.code || got.rep != want.rep ||
        got.run_end != want.run_end || got.text_end != want.text_end) begin
      $display("%0t: mismatch expected code=%h rep=%b run_end=%b text_end=%b",
               $realtime, want.code, want.rep, want.run_end, want.text_end);
      $display("%0t:          actual   code=%h rep=%b run_end=%b text_end=%b",
               $realtime, got.code, got.rep, got.run_end, got.text_end);
      fails++;
    end
  endfunction

  // input side prediction, output side checking and the sink's ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) accept_byte();
      if (m_axis_tvalid && m_axis_tready) check_unit();
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        // long hold-off so the result queue fills and the input stalls
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet_rx || ($urandom_range(99) >= 36);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_row(input byte_row_t r);
    while (!quiet_tx && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    sent_rows.insert(sent_rows.size(), r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.data;
    s_axis_tlast  <= r.fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (units_due.size() != 0 || sent_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    utf16_mode = m;
  endtask

  function automatic void plan_byte(input logic [7:0] b);
    byte_row_t r;
    r      = '0;
    r.data = b;
    plan_rows.insert(plan_rows.size(), r);
  endfunction

  // utf-8 form of cp in len bytes, of which only the first keep are queued
  function automatic void plan_seq(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] b [4];
    case (len)
      1: b[0] = cp[7:0];
      2: begin
        b[0] = {3'b110, cp[10:6]};
        b[1] = {2'b10, cp[5:0]};
      end
      3: begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) plan_byte(b[i]);
  endfunction

  function automatic logic [20:0] legal_cp(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SurrHigh && cp <= SurrLast) cp = cp - 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // mostly well-formed characters, with bad values, cut sequences and noise
  function automatic void plan_chunk();
    int kind;
    int len;
    int first;
    int pick;
    first = plan_rows.size();
    kind  = $urandom_range(99);
    if (kind < 72) begin
      len = (kind < 25) ? 1 : (kind < 42) ? 2 : (kind < 57) ? 3 : 4;
      plan_seq(legal_cp(len), len, len);
    end else if (kind < 78) begin
      case ($urandom_range(2))
        0: begin
          len = $urandom_range(2, 4);
          plan_seq(legal_cp(len - 1), len, len);
        end
        1: plan_seq(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
        default: plan_seq(21'($urandom_range('h110000, 'h13FFFF)), 4, 4);
      endcase
    end else if (kind < 86) begin
      len = $urandom_range(2, 4);
      plan_seq(legal_cp(len), len, $urandom_range(1, len - 1));
    end else if (kind < 93) begin
      case ($urandom_range(2))
        0: plan_byte(8'($urandom_range('h80, 'hBF)));
        1: plan_byte(8'($urandom_range('hC0, 'hC1)));
        default: plan_byte(8'($urandom_range('hF5, 'hFF)));
      endcase
    end else begin
      plan_byte(8'($urandom_range(255)));
    end
    // now and then end the text, sometimes in the middle of a sequence
    if ($urandom_range(99) < 9) begin
      pick = ($urandom_range(3) == 0) ? $urandom_range(first, plan_rows.size() - 1)
                                      : plan_rows.size() - 1;
      plan_rows[pick].fin = 1'b1;
    end
  endfunction

  task automatic run_random(input int quiet_bytes);
    byte_row_t r;
    int        sent;
    sent = 0;
    plan_rows.delete();
    while (plan_rows.size() < PhaseBytes) plan_chunk();
    // every phase ends a text so the decoder is idle for the next write
    plan_rows[plan_rows.size() - 1].fin = 1'b1;
    while (plan_rows.size() != 0) begin
      if (sent == quiet_bytes) begin
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
      end
      r = plan_rows.pop_front();
      send_row(r);
      sent++;
    end
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes in utf-16 mode
    write_mode(ModeUtf16);
    foreach (directed_rows[i]) send_row(directed_rows[i]);
    wait_idle();

    // code points, opening with a stretch where neither side idles
    write_mode(ModeCodePoint);
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    run_random(40);
    wait_idle();

    // utf-16 units with the sink holding off for a long time
    write_mode(ModeUtf16);
    hold_req = 1'b1;
    run_random(-1);
    wait_idle();

    // code points again with random idling on both sides
    write_mode(ModeCodePoint);
    run_random(-1);
    wait_idle();

    if (fails == 0) begin
      $display("utf8_validating_decoder test passed");
    end else begin
      $display("utf8_validating_decoder test failed");
    end
    $finish;
  end

endmodule
